>>> rtl/rnga_pkg.sv
`timescale 1ns / 1ps

package rnga_pkg;

  // ring geometry, fixed by the 4-bit client field
  localparam int MAX_CLIENTS = 16;
  localparam int IDX_W       = $clog2(MAX_CLIENTS);
  localparam int RING_W      = $clog2(MAX_CLIENTS + 1);
  localparam int MIN_RING    = 2;

  // field widths
  localparam int MODE_W     = 2;
  localparam int KIND_W     = 3;
  localparam int CNT_W      = 16;
  localparam int MEAL_W     = 16;
  localparam int CC_W       = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // reset values of the configuration
  localparam logic [CC_W-1:0]  CLIENT_COUNT_RESET  = CC_W'(5);
  localparam logic [CNT_W-1:0] PORTION_TOTAL_RESET = CNT_W'(10);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CLIENT_COUNT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PORTION_TOTAL = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    PH_THINK,
    PH_HUNGRY,
    PH_EAT,
    PH_GONE
  } phase_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_THINK,
    MODE_HUNGRY,
    MODE_CONSUME,
    MODE_RELEASE
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACK,
    KIND_GRANT,
    KIND_ATE,
    KIND_GONE,
    KIND_REJECT
  } kind_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_THINK,
    OP_HUNGRY,
    OP_TRY_GRANT,
    OP_EAT,
    OP_GONE
  } cell_op_t;

  // command broadcast along the row of cells
  typedef struct packed {
    cell_op_t         op;
    logic [IDX_W-1:0] sel;
    logic [IDX_W-1:0] ring_last;
  } cell_cmd_t;

  // view of the selected cell
  typedef struct packed {
    phase_t            phase;
    logic [MEAL_W-1:0] meal;
    logic              grant;
  } cell_stat_t;

  function automatic logic [MEAL_W-1:0] meal_inc(input logic [MEAL_W-1:0] m);
    logic [MEAL_W-1:0] res;
    res = (m == '1) ? m : m + 1'b1;
    return res;
  endfunction

endpackage

>>> rtl/ring_neighbour_grant_arbiter.sv
`timescale 1ns / 1ps

// ring neighbor grant arbiter: each client of a ring of up to 16 is thinking,
// hungry, eating or gone; an event (mode, client) is taken when start is high
// and busy is low, and produces one to three result beats, each on the out_
// ports for exactly one cycle with out_valid high and out_last on the final
// one. The receiver cannot stall, so it must take every beat as it comes.
// An event that yields a single beat (wrong-phase reject, think, hungry,
// consume with portions left) passes through S_FIRST and S_FLUSH with busy
// high and its beat appears in the first idle cycle; no new event is taken
// before then. A client outside the ring goes straight to S_FLUSH and is
// rejected. A release by an eater also passes S_GRANT_L and S_GRANT_R, a
// consume on an empty counter those and S_FINAL. The sequencer issues one
// cell operation per cycle (own client, left neighbor, right neighbor, then
// the gone marking) and holds each beat back so out_last marks the final one.
// configuration writes (client_count, portion_total) take effect at once and
// belong in idle periods; a portion_total write reloads the portion counter

module ring_neighbour_grant_arbiter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [rnga_pkg::MODE_W-1:0]     in_mode,
  input  logic [rnga_pkg::IDX_W-1:0]      in_client,
  output logic                            out_valid,
  output logic [rnga_pkg::KIND_W-1:0]     out_kind,
  output logic [rnga_pkg::IDX_W-1:0]      out_target,
  output logic [rnga_pkg::CNT_W-1:0]      out_portions_left,
  output logic [rnga_pkg::MEAL_W-1:0]     out_meals_taken,
  output logic                            out_last,
  input  logic                            cfg_we,
  input  logic [rnga_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rnga_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rnga_pkg::*;

  cell_cmd_t         cmd;
  cell_stat_t        stat;
  phase_t            phase_w [MAX_CLIENTS];
  logic [MEAL_W-1:0] meal_w  [MAX_CLIENTS];
  logic [MAX_CLIENTS-1:0] grant_w;

  // sequencer: event decode, portion counter, config, result beats
  rnga_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_mode           (in_mode),
    .in_client         (in_client),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .stat              (stat),
    .cmd               (cmd),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_target        (out_target),
    .out_portions_left (out_portions_left),
    .out_meals_taken   (out_meals_taken),
    .out_last          (out_last)
  );

  // row of client cells; each sees its two ring neighbors' phases, with
  // the ends closed at the active ring size
  for (genvar i = 0; i < MAX_CLIENTS; i++) begin : g_cell
    phase_t left_ph;
    phase_t right_ph;

    if (i == 0) begin : g_wrap_l
      assign left_ph = phase_w[cmd.ring_last];
    end else begin : g_plain_l
      assign left_ph = phase_w[i-1];
    end

    // last active cell wraps to cell 0
    assign right_ph = (IDX_W'(i) == cmd.ring_last) ? phase_w[0]
                                                   : phase_w[(i+1) % MAX_CLIENTS];

    rnga_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .my_idx      (IDX_W'(i)),
      .left_phase  (left_ph),
      .right_phase (right_ph),
      .phase       (phase_w[i]),
      .meal        (meal_w[i]),
      .grant       (grant_w[i])
    );
  end

  // only the addressed cell can grant, so a plain OR collects it
  assign stat.phase = phase_w[cmd.sel];
  assign stat.meal  = meal_w[cmd.sel];
  assign stat.grant = |grant_w;

endmodule

>>> rtl/rnga_cell.sv
`timescale 1ns / 1ps

module rnga_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  rnga_pkg::cell_cmd_t      cmd,
  input  logic [rnga_pkg::IDX_W-1:0] my_idx,
  input  rnga_pkg::phase_t         left_phase,
  input  rnga_pkg::phase_t         right_phase,
  output rnga_pkg::phase_t         phase,
  output logic [rnga_pkg::MEAL_W-1:0] meal,
  output logic                     grant
);
  import rnga_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [MEAL_W-1:0] meal_r, meal_nxt;
  logic              hit;
  logic              free;

  always_comb begin
    hit       = (cmd.sel == my_idx);
    free      = (left_phase != PH_EAT) && (right_phase != PH_EAT);
    phase_nxt = phase_r;
    meal_nxt  = meal_r;
    grant     = 1'b0;
    if (hit) begin
      case (cmd.op)
        OP_THINK: phase_nxt = PH_THINK;
        OP_HUNGRY: begin
          phase_nxt = free ? PH_EAT : PH_HUNGRY;
          grant     = free;
        end
        OP_TRY_GRANT: begin
          if (phase_r == PH_HUNGRY && free) begin
            phase_nxt = PH_EAT;
            grant     = 1'b1;
          end
        end
        OP_EAT:  meal_nxt  = meal_inc(meal_r);
        OP_GONE: phase_nxt = PH_GONE;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_THINK;
      meal_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      meal_r  <= meal_nxt;
    end
  end

  assign phase = phase_r;
  assign meal  = meal_r;

endmodule

>>> rtl/rnga_ctrl.sv
`timescale 1ns / 1ps

module rnga_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [rnga_pkg::MODE_W-1:0]     in_mode,
  input  logic [rnga_pkg::IDX_W-1:0]      in_client,
  input  logic                            cfg_we,
  input  logic [rnga_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rnga_pkg::CFG_DATA_W-1:0] cfg_data,
  input  rnga_pkg::cell_stat_t            stat,
  output rnga_pkg::cell_cmd_t             cmd,
  output logic                            out_valid,
  output logic [rnga_pkg::KIND_W-1:0]     out_kind,
  output logic [rnga_pkg::IDX_W-1:0]      out_target,
  output logic [rnga_pkg::CNT_W-1:0]      out_portions_left,
  output logic [rnga_pkg::MEAL_W-1:0]     out_meals_taken,
  output logic                            out_last
);
  import rnga_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_GRANT_L,
    S_GRANT_R,
    S_FINAL,
    S_FLUSH
  } state_t;

  state_t            state_r, state_nxt;
  mode_t             mode_r, mode_nxt;
  logic [IDX_W-1:0]  client_r, client_nxt;
  logic [IDX_W-1:0]  left_r, left_nxt;
  logic [IDX_W-1:0]  right_r, right_nxt;
  logic              gone_r, gone_nxt;
  logic [CC_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]  portion_r, portion_nxt;

  // one result held back until it is known whether another follows
  logic              pend_valid_r, pend_valid_nxt;
  kind_t             pend_kind_r, pend_kind_nxt;
  logic [IDX_W-1:0]  pend_target_r, pend_target_nxt;
  logic [CNT_W-1:0]  pend_portions_r, pend_portions_nxt;
  logic [MEAL_W-1:0] pend_meals_r, pend_meals_nxt;

  logic              out_valid_r, out_valid_nxt;
  kind_t             out_kind_r, out_kind_nxt;
  logic [IDX_W-1:0]  out_target_r, out_target_nxt;
  logic [CNT_W-1:0]  out_portions_r, out_portions_nxt;
  logic [MEAL_W-1:0] out_meals_r, out_meals_nxt;
  logic              out_last_r, out_last_nxt;

  logic [RING_W-1:0] ring_n;
  logic [IDX_W-1:0]  ring_last;
  logic              in_range;
  logic              idle_phase;
  logic              produce;
  kind_t             res_kind;
  logic [IDX_W-1:0]  res_target;
  logic [CNT_W-1:0]  res_portions;
  logic [MEAL_W-1:0] res_meals;

  always_comb begin
    // effective ring size
    if (count_r < RING_W'(MIN_RING)) begin
      ring_n = RING_W'(MIN_RING);
    end else if (count_r > RING_W'(MAX_CLIENTS)) begin
      ring_n = RING_W'(MAX_CLIENTS);
    end else begin
      ring_n = count_r;
    end
    ring_last  = IDX_W'(ring_n - 1'b1);
    in_range   = RING_W'(in_client) < ring_n;
    idle_phase = (stat.phase == PH_THINK) || (stat.phase == PH_HUNGRY);

    state_nxt         = state_r;
    mode_nxt          = mode_r;
    client_nxt        = client_r;
    left_nxt          = left_r;
    right_nxt         = right_r;
    gone_nxt          = gone_r;
    count_nxt         = count_r;
    portion_nxt       = portion_r;
    pend_valid_nxt    = pend_valid_r;
    pend_kind_nxt     = pend_kind_r;
    pend_target_nxt   = pend_target_r;
    pend_portions_nxt = pend_portions_r;
    pend_meals_nxt    = pend_meals_r;
    out_valid_nxt     = 1'b0;
    out_kind_nxt      = out_kind_r;
    out_target_nxt    = out_target_r;
    out_portions_nxt  = out_portions_r;
    out_meals_nxt     = out_meals_r;
    out_last_nxt      = 1'b0;

    cmd.op        = OP_NONE;
    cmd.sel       = client_r;
    cmd.ring_last = ring_last;

    produce      = 1'b0;
    res_kind     = KIND_REJECT;
    res_target   = client_r;
    res_portions = portion_r;
    res_meals    = stat.meal;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          mode_nxt   = mode_t'(in_mode);
          client_nxt = in_client;
          left_nxt   = (in_client == '0) ? ring_last : in_client - 1'b1;
          right_nxt  = (in_client == ring_last) ? '0 : in_client + 1'b1;
          gone_nxt   = 1'b0;
          if (in_range) begin
            state_nxt = S_FIRST;
          end else begin
            produce    = 1'b1;
            res_kind   = KIND_REJECT;
            res_target = in_client;
            res_meals  = '0;
            state_nxt  = S_FLUSH;
          end
        end
      end
      S_FIRST: begin
        produce   = 1'b1;
        state_nxt = S_FLUSH;
        case (mode_r)
          MODE_THINK: begin
            if (idle_phase) begin
              cmd.op   = OP_THINK;
              res_kind = KIND_ACK;
            end
          end
          MODE_HUNGRY: begin
            if (idle_phase) begin
              cmd.op   = OP_HUNGRY;
              res_kind = stat.grant ? KIND_GRANT : KIND_ACK;
            end
          end
          MODE_CONSUME: begin
            if (stat.phase == PH_EAT) begin
              if (portion_r != '0) begin
                cmd.op       = OP_EAT;
                portion_nxt  = portion_r - 1'b1;
                res_kind     = KIND_ATE;
                res_portions = portion_nxt;
                res_meals    = meal_inc(stat.meal);
              end else begin
                // counter empty: leave the table, neighbors get a chance first
                cmd.op    = OP_THINK;
                produce   = 1'b0;
                gone_nxt  = 1'b1;
                state_nxt = S_GRANT_L;
              end
            end
          end
          MODE_RELEASE: begin
            if (stat.phase == PH_EAT) begin
              cmd.op    = OP_THINK;
              res_kind  = KIND_ACK;
              state_nxt = S_GRANT_L;
            end
          end
          default: ;
        endcase
      end
      S_GRANT_L: begin
        cmd.op     = OP_TRY_GRANT;
        cmd.sel    = left_r;
        produce    = stat.grant;
        res_kind   = KIND_GRANT;
        res_target = left_r;
        state_nxt  = S_GRANT_R;
      end
      S_GRANT_R: begin
        cmd.op     = OP_TRY_GRANT;
        cmd.sel    = right_r;
        produce    = stat.grant;
        res_kind   = KIND_GRANT;
        res_target = right_r;
        state_nxt  = gone_r ? S_FINAL : S_FLUSH;
      end
      S_FINAL: begin
        cmd.op    = OP_GONE;
        produce   = 1'b1;
        res_kind  = KIND_GONE;
        state_nxt = S_FLUSH;
      end
      S_FLUSH: begin
        out_valid_nxt    = 1'b1;
        out_kind_nxt     = pend_kind_r;
        out_target_nxt   = pend_target_r;
        out_portions_nxt = pend_portions_r;
        out_meals_nxt    = pend_meals_r;
        out_last_nxt     = 1'b1;
        pend_valid_nxt   = 1'b0;
        state_nxt        = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    // a new result pushes the held one out as a non-final beat
    if (produce) begin
      if (pend_valid_r) begin
        out_valid_nxt    = 1'b1;
        out_kind_nxt     = pend_kind_r;
        out_target_nxt   = pend_target_r;
        out_portions_nxt = pend_portions_r;
        out_meals_nxt    = pend_meals_r;
        out_last_nxt     = 1'b0;
      end
      pend_valid_nxt    = 1'b1;
      pend_kind_nxt     = res_kind;
      pend_target_nxt   = res_target;
      pend_portions_nxt = res_portions;
      pend_meals_nxt    = res_meals;
    end

    if (cfg_we) begin
      case (cfg_index)
        REG_CLIENT_COUNT:  count_nxt   = cfg_data[CC_W-1:0];
        REG_PORTION_TOTAL: portion_nxt = cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      gone_r       <= 1'b0;
      count_r      <= CLIENT_COUNT_RESET;
      portion_r    <= PORTION_TOTAL_RESET;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      out_last_r   <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      mode_r          <= mode_nxt;
      client_r        <= client_nxt;
      left_r          <= left_nxt;
      right_r         <= right_nxt;
      gone_r          <= gone_nxt;
      count_r         <= count_nxt;
      portion_r       <= portion_nxt;
      pend_valid_r    <= pend_valid_nxt;
      pend_kind_r     <= pend_kind_nxt;
      pend_target_r   <= pend_target_nxt;
      pend_portions_r <= pend_portions_nxt;
      pend_meals_r    <= pend_meals_nxt;
      out_valid_r     <= out_valid_nxt;
      out_kind_r      <= out_kind_nxt;
      out_target_r    <= out_target_nxt;
      out_portions_r  <= out_portions_nxt;
      out_meals_r     <= out_meals_nxt;
      out_last_r      <= out_last_nxt;
    end
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_target        = out_target_r;
  assign out_portions_left = out_portions_r;
  assign out_meals_taken   = out_meals_r;
  assign out_last          = out_last_r;

endmodule

>>> rtl/rnga_chk.sv
`timescale 1ns / 1ps

module rnga_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic [rnga_pkg::KIND_W-1:0]     out_kind,
  input logic                            out_valid,
  input logic                            out_last
);
  import rnga_pkg::*;

  // an accepted event always occupies the block
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted event did not raise busy");

  // the final beat of an event shows while the block is idle again
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy)
    else $error("final beat while busy");

  // more beats are still coming while a non-final beat shows
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("non-final beat while idle");

  // no beat directly follows the final one
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("beat right after final beat");

  // a rejected event yields a single beat
  a_reject_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_REJECT |-> out_last)
    else $error("reject beat not final");

endmodule

bind ring_neighbour_grant_arbiter rnga_chk u_rnga_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_kind  (out_kind),
  .out_valid (out_valid),
  .out_last  (out_last)
);

>>> tb/ring_neighbour_grant_arbiter_test.sv
`timescale 1ns / 1ps

// self-checking bench for the ring neighbor grant arbiter
module ring_neighbour_grant_arbiter_test;
  import rnga_pkg::*;

  // no register lives at this index, writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);
  // cycles with no input beat, result beat or register write before giving up
  localparam int STALL_LIMIT = 600;

  // one result beat as the block should present it
  typedef struct packed {
    kind_t             kind;
    logic [IDX_W-1:0]  target;
    logic [CNT_W-1:0]  portions;
    logic [MEAL_W-1:0] meals;
    logic              last;
  } beat_t;

  typedef beat_t [2:0] beat_list_t;

  // one event offered on the input side
  typedef struct packed {
    mode_t            mode;
    logic [IDX_W-1:0] client;
  } event_t;

  // everything the arbiter remembers, plus the client_count register
  typedef struct packed {
    phase_t [MAX_CLIENTS-1:0]             phase;
    logic [MAX_CLIENTS-1:0][MEAL_W-1:0]   meals;
    logic [CNT_W-1:0]                     portions;
    logic [CC_W-1:0]                      clients;
  } ring_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [MODE_W-1:0]     in_mode = '0;
  logic [IDX_W-1:0]      in_client = '0;
  logic                  out_valid;
  logic [KIND_W-1:0]     out_kind;
  logic [IDX_W-1:0]      out_target;
  logic [CNT_W-1:0]      out_portions_left;
  logic [MEAL_W-1:0]     out_meals_taken;
  logic                  out_last;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // ring_live follows accepted beats, ring_plan follows generated events so
  // the generator knows who is eating once the queue has drained through
  ring_t  ring_live;
  ring_t  ring_plan;
  event_t pending_events[$];
  beat_t  due_beats[$];
  int     idle_pct = 0;
  int     gap_left = 0;
  int     mismatches = 0;
  int     stall_cycles = 0;

  ring_neighbour_grant_arbiter u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_mode           (in_mode),
    .in_client         (in_client),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_target        (out_target),
    .out_portions_left (out_portions_left),
    .out_meals_taken   (out_meals_taken),
    .out_last          (out_last),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ring size actually in use: register clamped to 2..MAX_CLIENTS
  function automatic int ring_size(ring_t r);
    if (r.clients < MIN_RING) return MIN_RING;
    if (r.clients > MAX_CLIENTS) return MAX_CLIENTS;
    return int'(r.clients);
  endfunction

  // snapshot of counter and meal count as seen right after the action
  function automatic beat_t make_beat(ring_t r, kind_t k, int t, int n);
    beat_t b;
    b.kind     = k;
    b.target   = IDX_W'(t);
    b.portions = r.portions;
    b.meals    = (t < n) ? r.meals[t] : '0;
    b.last     = 1'b0;
    return b;
  endfunction

  // hungry client with no eating neighbor gets the forks
  function automatic void grant_if_ready(inout ring_t r, input int c, input int n,
                                         inout beat_list_t beats, inout int k);
    int lft;
    int rgt;
    lft = (c + n - 1) % n;
    rgt = (c + 1) % n;
    if (r.phase[c] == PH_HUNGRY && r.phase[lft] != PH_EAT && r.phase[rgt] != PH_EAT) begin
      r.phase[c] = PH_EAT;
      beats[k]   = make_beat(r, KIND_GRANT, c, n);
      k++;
    end
  endfunction

  // applies one event to a ring and returns how many result beats it gives
  function automatic int serve_event(inout ring_t r, input event_t e,
                                     output beat_list_t beats);
    int     n;
    int     c;
    int     k;
    int     lft;
    int     rgt;
    phase_t ph;
    beats = '0;
    n     = ring_size(r);
    c     = int'(e.client);
    k     = 0;
    if (c >= n) begin
      // client beyond the ring in use
      beats[0] = make_beat(r, KIND_REJECT, c, n);
      k = 1;
    end else begin
      ph  = r.phase[c];
      lft = (c + n - 1) % n;
      rgt = (c + 1) % n;
      if (e.mode == MODE_THINK && (ph == PH_THINK || ph == PH_HUNGRY)) begin
        r.phase[c] = PH_THINK;
        beats[0]   = make_beat(r, KIND_ACK, c, n);
        k = 1;
      end else if (e.mode == MODE_HUNGRY && (ph == PH_THINK || ph == PH_HUNGRY)) begin
        r.phase[c] = PH_HUNGRY;
        grant_if_ready(r, c, n, beats, k);
        if (k == 0) begin
          beats[0] = make_beat(r, KIND_ACK, c, n);
          k = 1;
        end
      end else if (e.mode == MODE_CONSUME && ph == PH_EAT) begin
        if (r.portions != '0) begin
          r.portions = r.portions - 1'b1;
          if (r.meals[c] != '1) r.meals[c] = r.meals[c] + 1'b1;
          beats[0] = make_beat(r, KIND_ATE, c, n);
          k = 1;
        end else begin
          // empty counter: neighbors may take over, then the client leaves
          r.phase[c] = PH_THINK;
          grant_if_ready(r, lft, n, beats, k);
          grant_if_ready(r, rgt, n, beats, k);
          r.phase[c] = PH_GONE;
          beats[k]   = make_beat(r, KIND_GONE, c, n);
          k++;
        end
      end else if (e.mode == MODE_RELEASE && ph == PH_EAT) begin
        r.phase[c] = PH_THINK;
        beats[0]   = make_beat(r, KIND_ACK, c, n);
        k = 1;
        grant_if_ready(r, lft, n, beats, k);
        grant_if_ready(r, rgt, n, beats, k);
      end else begin
        // wrong phase, gone clients included
        beats[0] = make_beat(r, KIND_REJECT, c, n);
        k = 1;
      end
    end
    beats[k-1].last = 1'b1;
    return k;
  endfunction

  function automatic void load_reg(inout ring_t r, input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] data);
    if (idx == REG_CLIENT_COUNT) r.clients = data[CC_W-1:0];
    else if (idx == REG_PORTION_TOTAL) r.portions = data[CNT_W-1:0];
  endfunction

  // mostly sensible moves for the client's phase, with some noise mixed in
  function automatic event_t pick_event(ring_t r);
    event_t e;
    int     n;
    int     c;
    int     roll;
    n = ring_size(r);
    if ($urandom_range(0, 99) < 10) begin
      e.mode   = mode_t'($urandom_range(0, 3));
      e.client = IDX_W'($urandom_range(0, MAX_CLIENTS - 1));
      return e;
    end
    c = $urandom_range(0, n - 1);
    for (int tries = 0; tries < 3 && r.phase[c] == PH_GONE; tries++)
      c = $urandom_range(0, n - 1);
    roll = $urandom_range(0, 99);
    case (r.phase[c])
      PH_EAT: begin
        if (roll < 65) e.mode = MODE_CONSUME;
        else if (roll < 92) e.mode = MODE_RELEASE;
        else if (roll < 96) e.mode = MODE_THINK;
        else e.mode = MODE_HUNGRY;
      end
      PH_GONE: begin
        e.mode = mode_t'($urandom_range(0, 3));
      end
      default: begin
        if (roll < 70) e.mode = MODE_HUNGRY;
        else if (roll < 94) e.mode = MODE_THINK;
        else if (roll < 97) e.mode = MODE_CONSUME;
        else e.mode = MODE_RELEASE;
      end
    endcase
    e.client = IDX_W'(c);
    return e;
  endfunction

  // queue an event for the driver and advance the planning copy
  task automatic queue_event(input mode_t m, input int c);
    event_t     e;
    beat_list_t spare;
    e.mode   = m;
    e.client = IDX_W'(c);
    void'(serve_event(ring_plan, e, spare));
    pending_events.push_back(e);
  endtask

  task automatic queue_random(input int count);
    event_t     e;
    beat_list_t spare;
    repeat (count) begin
      e = pick_event(ring_plan);
      void'(serve_event(ring_plan, e, spare));
      pending_events.push_back(e);
    end
  endtask

  // one register write, only ever issued while the arbiter is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    load_reg(ring_live, idx, data);
    load_reg(ring_plan, idx, data);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // all events sent, every beat back, arbiter no longer busy; sampled at the
  // falling edge so the driver's updates of the rising edge have settled
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_events.size() != 0 || start || due_beats.size() != 0 || busy);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic flag_mismatch(input string why, input beat_t want);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch (%s): expected kind %0d target %0d portions %0d meals %0d last %0b,",
               why, want.kind, want.target, want.portions, want.meals, want.last,
               " got kind %0d target %0d portions %0d meals %0d last %0b",
               out_kind, out_target, out_portions_left, out_meals_taken, out_last);
  endtask

  // input side: holds an event until the arbiter takes it, then may idle
  always @(posedge clk) begin : drive
    beat_list_t beats;
    event_t     ev;
    int         k;
    bit         took;
    took = rst_n && start && !busy;
    if (took) begin
      ev.mode   = mode_t'(in_mode);
      ev.client = in_client;
      k = serve_event(ring_live, ev, beats);
      for (int i = 0; i < k; i++) due_beats.push_back(beats[i]);
    end
    if (took || !start) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (rst_n && pending_events.size() != 0) begin
        ev = pending_events.pop_front();
        in_mode   <= ev.mode;
        in_client <= ev.client;
        start     <= 1'b1;
        // idle burst after this beat is taken
        if ($urandom_range(1, 100) <= idle_pct) gap_left = $urandom_range(1, 11);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result side: every strobed beat must match the oldest expectation
  always @(posedge clk) begin : watch
    beat_t want;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (due_beats.size() == 0) begin
          flag_mismatch("beat with nothing expected", '0);
        end else begin
          want = due_beats.pop_front();
          if (out_kind !== want.kind || out_target !== want.target ||
              out_portions_left !== want.portions || out_meals_taken !== want.meals ||
              out_last !== want.last)
            flag_mismatch("field differs", want);
        end
      end
      // watchdog on lack of progress
      if ((start && !busy) || out_valid === 1'b1 || cfg_we) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    logic [CC_W-1:0]  cc;
    logic [CNT_W-1:0] total;
    ring_live          = '0;
    ring_live.clients  = CLIENT_COUNT_RESET;
    ring_live.portions = PORTION_TOTAL_RESET;
    ring_plan          = ring_live;
    idle_pct           = 20;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset ring of five: grant, blocked neighbor, release granting both sides
    queue_event(MODE_HUNGRY, 0);
    queue_event(MODE_HUNGRY, 1);
    queue_event(MODE_CONSUME, 0);
    queue_event(MODE_THINK, 1);
    queue_event(MODE_HUNGRY, 1);
    queue_event(MODE_HUNGRY, 4);
    queue_event(MODE_RELEASE, 0);
    // wrong phase and outside the ring
    queue_event(MODE_CONSUME, 2);
    queue_event(MODE_RELEASE, 3);
    queue_event(MODE_THINK, 4);
    queue_event(MODE_HUNGRY, 5);
    queue_event(MODE_CONSUME, 15);
    wait_idle();

    // count below the minimum: two-client ring, both neighbors the same client
    write_reg(REG_CLIENT_COUNT, CFG_DATA_W'(1));
    @(negedge clk);
    queue_event(MODE_HUNGRY, 0);
    queue_event(MODE_RELEASE, 1);
    queue_event(MODE_CONSUME, 0);
    queue_event(MODE_HUNGRY, 1);
    queue_event(MODE_THINK, 2);
    wait_idle();

    // count above the maximum acts as a full ring
    write_reg(REG_CLIENT_COUNT, CFG_DATA_W'(31));
    @(negedge clk);
    queue_event(MODE_HUNGRY, 15);
    queue_event(MODE_HUNGRY, 3);
    wait_idle();

    // empty counter: consumers leave, hungry neighbors (both sides) take over
    write_reg(REG_PORTION_TOTAL, '0);
    @(negedge clk);
    queue_event(MODE_CONSUME, 4);
    queue_event(MODE_CONSUME, 0);
    queue_event(MODE_THINK, 0);
    queue_event(MODE_HUNGRY, 0);
    queue_event(MODE_CONSUME, 0);
    queue_event(MODE_RELEASE, 0);
    wait_idle();

    // write to a nonexistent register must change nothing
    write_reg(REG_SPARE, '1);

    // a run of consumes from one client, back to back
    idle_pct = 0;
    write_reg(REG_PORTION_TOTAL, '1);
    @(negedge clk);
    for (int i = 0; i < 16 && ring_plan.phase[1] == PH_EAT &&
         ring_plan.portions != '0; i++)
      queue_event(MODE_CONSUME, 1);
    wait_idle();
    write_reg(REG_PORTION_TOTAL, '1);
    @(negedge clk);
    queue_event(MODE_CONSUME, 1);
    queue_event(MODE_CONSUME, 1);
    wait_idle();

    // random traffic over several ring sizes and counter loads
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: cc = CC_W'(2);
        1: cc = CC_W'(16);
        2: cc = CC_W'(0);
        3: cc = CC_W'($urandom_range(3, 15));
        4: cc = CC_W'($urandom_range(17, 31));
        5: cc = CC_W'(7);
        6: cc = CC_W'(1);
        default: cc = CC_W'(16);
      endcase
      case (p)
        1: total = '1;
        6: total = CNT_W'(1);
        7: total = CNT_W'($urandom_range(2, 6));
        default: total = CNT_W'($urandom_range(100, 65535));
      endcase
      // upper data bits are junk for client_count
      write_reg(REG_CLIENT_COUNT, {(CFG_DATA_W - CC_W)'($urandom), cc});
      write_reg(REG_PORTION_TOTAL, total);
      // stretches without idling, light and heavy bursts; none at the end
      if (p == 7) idle_pct = 0;
      else if (p % 3 == 0) idle_pct = 0;
      else if (p % 3 == 1) idle_pct = 25;
      else idle_pct = 60;
      @(negedge clk);
      queue_random(60);
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && due_beats.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
